@@ hw/rtl/positional_list_engine_defines.svh @@
// assertion macros shared by the positional list engine rtl
`ifndef POSITIONAL_LIST_ENGINE_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_DEFINES_SVH

// condition that must hold at every clock edge out of reset
`define PLE_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// same-cycle implication
`define PLE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PLE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/ple_pkg.sv @@
// package with codes, field widths and helpers for the positional list engine
package ple_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;

    // fixed field widths of the stream beats
    localparam int CMD_W     = 3;
    localparam int POS_W     = 7;
    localparam int VAL_W     = 32;
    localparam int ST_W      = 2;
    localparam int DOUT_W    = 32;
    localparam int FIDX_W    = 6;
    localparam int CNT_W     = 7;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;

    // fan-in of one node of the selection tree
    localparam int FAN = 8;

    localparam logic [CMD_W-1:0] CMD_GET    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SET    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd2;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd4;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd5;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE    = 2'd1;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL     = 2'd3;

    // broadcast control for every cell of the chain
    typedef struct packed {
        logic wr;
        logic shift_up;
        logic shift_down;
        logic search;
    } t_cell_ctl;

    // per-command info that travels beside the selection tree
    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic             is_search;
        logic             is_read;
        logic [CNT_W-1:0] count;
        logic             empty;
    } t_side;

    // number of nodes at tree level lvl over n leaves
    function automatic int lvl_width(input int n, input int lvl);
        int w;
        w = n;
        for (int i = 0; i <= lvl; i++) begin
            w = (w + FAN - 1) / FAN;
        end
        return w;
    endfunction

    // registered levels needed to reduce n leaves to one node
    function automatic int tree_levels(input int n);
        int w;
        int lv;
        w  = (n + FAN - 1) / FAN;
        lv = 1;
        while (w > 1) begin
            w  = (w + FAN - 1) / FAN;
            lv = lv + 1;
        end
        return lv;
    endfunction

endpackage

@@ hw/rtl/positional_list_engine.sv @@
// top level of the positional list engine: chain of cells, selection tree, result stage
//
// Command beats enter on the s_axis channel: tuser carries the command (get, set,
// append, insert, remove, search), tdata the position and the value. Every command
// gives exactly one result beat on m_axis: tuser carries the status, tdata the
// element read, the found index, the element count after the command and an
// empty flag.
// The list lives in a chain of CAPACITY cells. At the beat's clock edge the cells from
// the position upward write, shift up or shift down by one place as the command needs,
// so the list is up to date for the very next command. The old element (get, set,
// remove) or the first search match is picked by a registered tree with fan-in 8,
// each tree level registered, followed by the result register. Throughput: one
// command per cycle while m_axis_tready does not stall the waiting result.
// Reset (synchronous, active low) empties the list and drops results in flight;
// cell contents are not cleared, only elements below the count are ever read.
// When the receiver holds m_axis_tready low with a result waiting, the whole
// pipeline and s_axis_tready stall until that beat is taken.
module positional_list_engine #(
    parameter int CAPACITY   = ple_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = ple_pkg::DATA_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [ple_pkg::S_TDATA_W-1:0] s_axis_tdata,  // position, value
    input  logic [ple_pkg::CMD_W-1:0]     s_axis_tuser,  // command
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [ple_pkg::M_TDATA_W-1:0] m_axis_tdata,  // data, found_index, count, empty_res
    output logic [ple_pkg::ST_W-1:0]      m_axis_tuser   // status
);

    `include "positional_list_engine_defines.svh"

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int LEN_W  = $clog2(CAPACITY + 1);
    localparam int LEVELS = ple_pkg::tree_levels(CAPACITY);
    localparam int CMP_W  = (LEN_W > ple_pkg::POS_W) ? LEN_W : ple_pkg::POS_W;
    localparam int KEY_XW = (DATA_WIDTH > ple_pkg::VAL_W) ? DATA_WIDTH : ple_pkg::VAL_W;
    localparam int DAT_XW = (DATA_WIDTH > ple_pkg::DOUT_W) ? DATA_WIDTH : ple_pkg::DOUT_W;
    localparam int FIX_XW = (IDX_W > ple_pkg::FIDX_W) ? IDX_W : ple_pkg::FIDX_W;
    localparam int CNT_XW = (LEN_W > ple_pkg::CNT_W) ? LEN_W : ple_pkg::CNT_W;
    localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAPACITY);

    logic [ple_pkg::CMD_W-1:0] w_cmd;
    logic [ple_pkg::POS_W-1:0] w_pos;
    logic [ple_pkg::VAL_W-1:0] w_val;
    logic                      w_adv;
    logic                      w_acc;

    logic [CMP_W-1:0]          w_pos_c;
    logic [CMP_W-1:0]          w_len_c;
    logic                      w_in_rng;
    logic                      w_ins_rng;
    logic                      w_full;
    logic [KEY_XW-1:0]         w_key_x;
    logic [DATA_WIDTH-1:0]     w_key;

    ple_pkg::t_cell_ctl        w_ctl;
    logic [IDX_W-1:0]          w_wpos;
    ple_pkg::t_side            w_side;
    logic [LEN_W-1:0]          n_len;
    logic [LEN_W-1:0]          r_len;

    logic [DATA_WIDTH-1:0]     w_cell_data [CAPACITY];
    logic [CAPACITY-1:0]       w_hit;

    logic                      w_top_hit;
    logic [DATA_WIDTH-1:0]     w_top_data;
    logic [IDX_W-1:0]          w_top_idx;

    logic                      r_vld  [LEVELS];
    ple_pkg::t_side            r_side [LEVELS];

    logic                         r_out_vld;
    logic [ple_pkg::ST_W-1:0]     r_out_status;
    logic [ple_pkg::DOUT_W-1:0]   r_out_data;
    logic [ple_pkg::FIDX_W-1:0]   r_out_idx;
    logic [ple_pkg::CNT_W-1:0]    r_out_count;
    logic                         r_out_empty;
    logic [ple_pkg::ST_W-1:0]     n_out_status;
    logic [ple_pkg::DOUT_W-1:0]   n_out_data;
    logic [ple_pkg::FIDX_W-1:0]   n_out_idx;
    logic [DAT_XW-1:0]            w_data_x;
    logic [FIX_XW-1:0]            w_idx_x;
    logic [CNT_XW-1:0]            w_cnt_x;

    assign w_cmd = s_axis_tuser;
    assign w_pos = s_axis_tdata[ple_pkg::POS_W-1:0];
    assign w_val = s_axis_tdata[ple_pkg::POS_W +: ple_pkg::VAL_W];

    // whole pipeline moves whenever the result register is free or being drained
    assign w_adv         = !r_out_vld || m_axis_tready;
    assign s_axis_tready = w_adv;
    assign w_acc         = s_axis_tvalid && w_adv;

    assign w_pos_c   = CMP_W'(w_pos);
    assign w_len_c   = CMP_W'(r_len);
    assign w_in_rng  = (w_pos_c < w_len_c);
    assign w_ins_rng = (w_pos_c <= w_len_c);
    assign w_full    = (r_len == CAP_LEN);
    // only the low DATA_WIDTH bits of the value are stored and compared
    assign w_key_x   = KEY_XW'(w_val);
    assign w_key     = w_key_x[DATA_WIDTH-1:0];

    always_comb begin
        w_ctl            = '0;
        w_wpos           = w_pos_c[IDX_W-1:0];
        n_len            = r_len;
        w_side           = '0;
        w_side.status    = ple_pkg::ST_OK;
        case (w_cmd)
            ple_pkg::CMD_GET: begin
                if (w_in_rng) begin
                    w_side.is_read = 1'b1;
                end else begin
                    w_side.status = ple_pkg::ST_RANGE;
                end
            end
            ple_pkg::CMD_SET: begin
                if (w_in_rng) begin
                    w_side.is_read = 1'b1;
                    w_ctl.wr       = 1'b1;
                end else begin
                    w_side.status = ple_pkg::ST_RANGE;
                end
            end
            ple_pkg::CMD_APPEND: begin
                w_wpos = r_len[IDX_W-1:0];
                if (w_full) begin
                    w_side.status = ple_pkg::ST_FULL;
                end else begin
                    w_ctl.wr = 1'b1;
                    n_len    = r_len + 1'b1;
                end
            end
            ple_pkg::CMD_INSERT: begin
                if (!w_ins_rng) begin
                    w_side.status = ple_pkg::ST_RANGE;
                end else if (w_full) begin
                    w_side.status = ple_pkg::ST_FULL;
                end else begin
                    w_ctl.wr       = 1'b1;
                    w_ctl.shift_up = 1'b1;
                    n_len          = r_len + 1'b1;
                end
            end
            ple_pkg::CMD_REMOVE: begin
                if (w_in_rng) begin
                    w_side.is_read   = 1'b1;
                    w_ctl.shift_down = 1'b1;
                    n_len            = r_len - 1'b1;
                end else begin
                    w_side.status = ple_pkg::ST_RANGE;
                end
            end
            ple_pkg::CMD_SEARCH: begin
                w_ctl.search     = 1'b1;
                w_side.is_search = 1'b1;
            end
            default: begin
                w_side.status = ple_pkg::ST_RANGE;
            end
        endcase
        w_cnt_x      = CNT_XW'(n_len);
        w_side.count = w_cnt_x[ple_pkg::CNT_W-1:0];
        w_side.empty = (n_len == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else if (w_acc) begin
            r_len <= n_len;
        end
    end

    // cell chain
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_lo;
        logic [DATA_WIDTH-1:0] w_hi;
        if (i == 0) begin : g_first
            assign w_lo = '0;
        end else begin : g_lo
            assign w_lo = w_cell_data[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign w_hi = w_cell_data[i];
        end else begin : g_hi
            assign w_hi = w_cell_data[i+1];
        end
        ple_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .IDX_W      (IDX_W),
            .LEN_W      (LEN_W),
            .INDEX      (i)
        ) u_cell (
            .i_clk  (i_clk),
            .i_en   (w_acc),
            .i_ctl  (w_ctl),
            .i_wpos (w_wpos),
            .i_len  (r_len),
            .i_key  (w_key),
            .i_lo   (w_lo),
            .i_hi   (w_hi),
            .o_data (w_cell_data[i]),
            .o_hit  (w_hit[i])
        );
    end

    ple_tree #(
        .DATA_WIDTH (DATA_WIDTH),
        .LEAVES     (CAPACITY),
        .IDX_W      (IDX_W)
    ) u_tree (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_hit  (w_hit),
        .i_data (w_cell_data),
        .o_hit  (w_top_hit),
        .o_data (w_top_data),
        .o_idx  (w_top_idx)
    );

    // command info runs in step with the tree levels
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < LEVELS; l++) begin
                r_vld[l] <= 1'b0;
            end
        end else if (w_adv) begin
            r_vld[0] <= s_axis_tvalid;
            for (int l = 1; l < LEVELS; l++) begin
                r_vld[l] <= r_vld[l-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_side[0] <= w_side;
            for (int l = 1; l < LEVELS; l++) begin
                r_side[l] <= r_side[l-1];
            end
        end
    end

    always_comb begin
        w_data_x     = DAT_XW'(w_top_data);
        w_idx_x      = FIX_XW'(w_top_idx);
        n_out_status = r_side[LEVELS-1].status;
        n_out_data   = '0;
        n_out_idx    = '0;
        if (r_side[LEVELS-1].is_search) begin
            if (w_top_hit) begin
                n_out_status = ple_pkg::ST_OK;
                n_out_idx    = w_idx_x[ple_pkg::FIDX_W-1:0];
            end else begin
                n_out_status = ple_pkg::ST_NOTFOUND;
            end
        end
        if (r_side[LEVELS-1].is_read) begin
            n_out_data = w_data_x[ple_pkg::DOUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= r_vld[LEVELS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_status <= n_out_status;
            r_out_data   <= n_out_data;
            r_out_idx    <= n_out_idx;
            r_out_count  <= r_side[LEVELS-1].count;
            r_out_empty  <= r_side[LEVELS-1].empty;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {2'b00, r_out_empty, r_out_count, r_out_idx, r_out_data};

    `PLE_ASSERT(a_len_bound, r_len <= CAP_LEN, "list length beyond capacity")
    `PLE_ASSERT_NXT(a_len_hold, !w_acc, $stable(r_len), "length changed without a command")
    `PLE_ASSERT_IMP(a_read_hits, r_vld[LEVELS-1] && r_side[LEVELS-1].is_read, w_top_hit,
        "selection tree lost the addressed cell")
    `PLE_ASSERT_IMP(a_stall, m_axis_tvalid && !m_axis_tready, !s_axis_tready,
        "command taken while result stalled")

endmodule

@@ hw/rtl/ple_cell.sv @@
// one storage cell of the list chain: holds one element and flags a hit
module ple_cell #(
    parameter int DATA_WIDTH = ple_pkg::DATA_WIDTH_DEF,
    parameter int IDX_W      = 6,
    parameter int LEN_W      = 7,
    parameter int INDEX      = 0
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  ple_pkg::t_cell_ctl    i_ctl,
    input  logic [IDX_W-1:0]      i_wpos,
    input  logic [LEN_W-1:0]      i_len,
    input  logic [DATA_WIDTH-1:0] i_key,
    input  logic [DATA_WIDTH-1:0] i_lo,
    input  logic [DATA_WIDTH-1:0] i_hi,
    output logic [DATA_WIDTH-1:0] o_data,
    output logic                  o_hit
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);
    localparam logic [LEN_W-1:0] MY_LEN = LEN_W'(INDEX);

    logic [DATA_WIDTH-1:0] r_data;
    logic                  w_at;
    logic                  w_above;

    assign w_at    = (MY_IDX == i_wpos);
    assign w_above = (MY_IDX > i_wpos);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_ctl.shift_up && w_above) begin
                r_data <= i_lo;
            end else if (i_ctl.shift_down && (w_above || w_at)) begin
                r_data <= i_hi;
            end else if (i_ctl.wr && w_at) begin
                r_data <= i_key;
            end
        end
    end

    // search hit only counts inside the list, otherwise select by position
    assign o_hit  = i_ctl.search ? ((MY_LEN < i_len) && (r_data == i_key)) : w_at;
    assign o_data = r_data;

endmodule

@@ hw/rtl/ple_tree.sv @@
// registered priority tree that picks the lowest hit cell and its element
module ple_tree #(
    parameter int DATA_WIDTH = ple_pkg::DATA_WIDTH_DEF,
    parameter int LEAVES     = ple_pkg::CAPACITY_DEF,
    parameter int IDX_W      = 6
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [LEAVES-1:0]     i_hit,
    input  logic [DATA_WIDTH-1:0] i_data [LEAVES],
    output logic                  o_hit,
    output logic [DATA_WIDTH-1:0] o_data,
    output logic [IDX_W-1:0]      o_idx
);

    localparam int LEVELS = ple_pkg::tree_levels(LEAVES);
    localparam int W0     = ple_pkg::lvl_width(LEAVES, 0);

    typedef struct packed {
        logic                  hit;
        logic [DATA_WIDTH-1:0] data;
        logic [IDX_W-1:0]      idx;
    } t_node;

    t_node r_node [LEVELS][W0];
    t_node n_node [LEVELS][W0];

    for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
        localparam int WP = (l == 0) ? LEAVES : ple_pkg::lvl_width(LEAVES, l - 1);
        localparam int WL = ple_pkg::lvl_width(LEAVES, l);
        for (genvar n = 0; n < W0; n++) begin : g_node
            if (n < WL) begin : g_act
                t_node ch [ple_pkg::FAN];
                for (genvar k = 0; k < ple_pkg::FAN; k++) begin : g_ch
                    if (ple_pkg::FAN * n + k < WP) begin : g_in
                        if (l == 0) begin : g_leaf
                            assign ch[k] = {i_hit[ple_pkg::FAN * n + k],
                                            i_data[ple_pkg::FAN * n + k],
                                            IDX_W'(ple_pkg::FAN * n + k)};
                        end else begin : g_inner
                            assign ch[k] = r_node[l-1][ple_pkg::FAN * n + k];
                        end
                    end else begin : g_pad
                        assign ch[k] = '0;
                    end
                end
                // lowest hit child wins
                always_comb begin
                    n_node[l][n] = '0;
                    for (int k = ple_pkg::FAN - 1; k >= 0; k--) begin
                        if (ch[k].hit) begin
                            n_node[l][n] = ch[k];
                        end
                    end
                end
            end else begin : g_idle
                assign n_node[l][n] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_node <= n_node;
        end
    end

    assign o_hit  = r_node[LEVELS-1][0].hit;
    assign o_data = r_node[LEVELS-1][0].data;
    assign o_idx  = r_node[LEVELS-1][0].idx;

endmodule
